// ----- rtl/lsh_pkg.sv -----
// Package with the codes, constants and types of the link set-up handshake unit.
package lsh_pkg;

  localparam logic [7:0] FLAG_BYTE = 8'h7E;
  localparam logic [7:0] ADDR_BYTE = 8'h03;
  localparam logic [7:0] CTRL_SET  = 8'h03;
  localparam logic [7:0] CTRL_UA   = 8'h07;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_BYTE  = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  localparam logic [1:0] REG_ROLE     = 2'd0;
  localparam logic [1:0] REG_TIMEOUT  = 2'd1;
  localparam logic [1:0] REG_MAX_TOUT = 2'd2;

  localparam logic [2:0] PH_IDLE      = 3'd0;
  localparam logic [2:0] PH_TX_FLAG   = 3'd1;
  localparam logic [2:0] PH_TX_BODY   = 3'd2;
  localparam logic [2:0] PH_RX_FLAG   = 3'd3;
  localparam logic [2:0] PH_RX_BODY   = 3'd4;
  localparam logic [2:0] PH_DONE_OK   = 3'd5;
  localparam logic [2:0] PH_DONE_FAIL = 3'd6;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_BUSY   = 2'd1;
  localparam logic [1:0] ST_CONN   = 2'd2;
  localparam logic [1:0] ST_FAILED = 2'd3;

  localparam int unsigned FRAME_LEN = 5;
  localparam int unsigned IDX_W     = $clog2(FRAME_LEN);

  typedef enum logic [1:0] {
    FR_NONE = 2'd0,
    FR_SET  = 2'd1,
    FR_UA   = 2'd2
  } frame_kind_t;

  typedef struct packed {
    frame_kind_t kind;
    logic [7:0]  addr;
    logic [1:0]  status;
  } frame_desc_t;

  function automatic logic [1:0] phase_status(input logic [2:0] ph);
    logic [1:0] st;
    st = ST_BUSY;
    if (ph == PH_IDLE) st = ST_IDLE;
    else if (ph == PH_DONE_OK) st = ST_CONN;
    else if (ph == PH_DONE_FAIL) st = ST_FAILED;
    return st;
  endfunction

endpackage

// ----- rtl/link_setup_handshake_unit.sv -----
// Link set-up handshake unit: SET / UA style exchange on a serial line, byte stream in and out.
//
// The input channel carries one beat per event: in_tuser holds the opcode (start, received
// line byte, timer tick) and in_tdata the received byte. The output channel carries one beat
// per line byte to send: out_tdata holds the byte and the link status after the event,
// out_tuser says whether the byte is to be sent, and out_tlast marks the last beat of an event.
// An event that sends nothing gives one beat with out_tuser low. The configuration channel
// writes role, timeout tick count and timeout limit; the user must do so only while the unit is
// idle, as the unit itself does not enforce it.
// The link state is updated in the cycle an event is accepted; the event's frame descriptor
// goes to a one-entry holding register and then to the serializer register, which drives the
// first output beat. The unit accepts one event per cycle while each event yields a single
// beat and the receiver takes every beat; an event that sends a frame keeps the serializer
// busy for its five beats, which sets the sustained rate. The holding register lets one
// further event be accepted while a frame drains. When the receiver stalls, beats hold and
// the input stalls once the holding register is full. Reset returns the link to idle and loads
// the register defaults (transmitter, three ticks, three timeouts); no clearing pass is needed.
module link_setup_handshake_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic [1:0]  in_tuser,   // [1:0] opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] tx_byte, [9:8] link_status, [15:10] zero
  output logic        out_tuser,  // [0] tx_valid
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic                   role_r;
  logic [15:0]            tout_ticks_r;
  logic [3:0]             max_tout_r;

  logic [2:0]             phase_r, phase_nxt;
  logic [1:0]             byte_idx_r, byte_idx_nxt;
  logic [7:0]             frame_r [3];
  logic [15:0]            tick_r, tick_nxt;
  logic [3:0]             tout_cnt_r, tout_cnt_nxt;

  lsh_pkg::frame_kind_t   kind_nxt;

  logic                   pend_v_r;
  lsh_pkg::frame_desc_t   pend_r;
  logic                   emit_v_r;
  lsh_pkg::frame_desc_t   emit_r;
  logic [lsh_pkg::IDX_W-1:0] emit_idx_r;

  logic                   in_acc;
  logic                   last_beat;
  logic                   emit_done;
  logic                   load;
  logic [15:0]            tick_inc;
  logic [3:0]             tout_inc;
  logic                   check_ok;
  logic [7:0]             out_byte;

  assign cfg_ready = 1'b1;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      role_r       <= 1'b0;
      tout_ticks_r <= 16'd3;
      max_tout_r   <= 4'd3;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        lsh_pkg::REG_ROLE:     role_r       <= cfg_data[0];
        lsh_pkg::REG_TIMEOUT:  tout_ticks_r <= cfg_data;
        lsh_pkg::REG_MAX_TOUT: max_tout_r   <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  assign tick_inc = tick_r + 16'd1;
  assign tout_inc = tout_cnt_r + 4'd1;
  assign check_ok = frame_r[2] == (frame_r[0] ^ frame_r[1]);

  always_comb begin
    phase_nxt    = phase_r;
    byte_idx_nxt = byte_idx_r;
    tick_nxt     = tick_r;
    tout_cnt_nxt = tout_cnt_r;
    kind_nxt     = lsh_pkg::FR_NONE;
    case (in_tuser)
      lsh_pkg::OP_START: begin
        byte_idx_nxt = 2'd0;
        tick_nxt     = 16'd0;
        tout_cnt_nxt = 4'd0;
        if (!role_r) begin
          phase_nxt = lsh_pkg::PH_TX_FLAG;
          kind_nxt  = lsh_pkg::FR_SET;
        end else begin
          phase_nxt = lsh_pkg::PH_RX_FLAG;
        end
      end
      lsh_pkg::OP_BYTE: begin
        if (phase_r == lsh_pkg::PH_TX_FLAG || phase_r == lsh_pkg::PH_RX_FLAG) begin
          if (in_tdata == lsh_pkg::FLAG_BYTE) begin
            phase_nxt    = (phase_r == lsh_pkg::PH_TX_FLAG) ? lsh_pkg::PH_TX_BODY
                                                             : lsh_pkg::PH_RX_BODY;
            byte_idx_nxt = 2'd0;
          end
        end else if (phase_r == lsh_pkg::PH_TX_BODY || phase_r == lsh_pkg::PH_RX_BODY) begin
          byte_idx_nxt = byte_idx_r + 2'd1;
          if (byte_idx_r == 2'd3) begin
            byte_idx_nxt = 2'd0;
            if (phase_r == lsh_pkg::PH_RX_BODY) begin
              if (check_ok) begin
                phase_nxt = lsh_pkg::PH_DONE_OK;
                kind_nxt  = lsh_pkg::FR_UA;
              end else begin
                phase_nxt = lsh_pkg::PH_RX_FLAG;
              end
            end else if (check_ok) begin
              phase_nxt = (frame_r[1] == lsh_pkg::CTRL_UA) ? lsh_pkg::PH_DONE_OK
                                                           : lsh_pkg::PH_DONE_FAIL;
            end else begin
              phase_nxt = lsh_pkg::PH_TX_FLAG;
              tick_nxt  = 16'd0;
              kind_nxt  = lsh_pkg::FR_SET;
            end
          end
        end
      end
      lsh_pkg::OP_TICK: begin
        if (phase_r == lsh_pkg::PH_TX_FLAG || phase_r == lsh_pkg::PH_TX_BODY) begin
          tick_nxt = tick_inc;
          if (tick_inc >= tout_ticks_r) begin
            tick_nxt     = 16'd0;
            tout_cnt_nxt = tout_inc;
            if (tout_inc >= max_tout_r || tout_inc == 4'd0) begin
              phase_nxt = lsh_pkg::PH_DONE_FAIL;
            end else begin
              phase_nxt    = lsh_pkg::PH_TX_FLAG;
              byte_idx_nxt = 2'd0;
              kind_nxt     = lsh_pkg::FR_SET;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= lsh_pkg::PH_IDLE;
      byte_idx_r <= 2'd0;
      tick_r     <= 16'd0;
      tout_cnt_r <= 4'd0;
    end else if (in_acc) begin
      phase_r    <= phase_nxt;
      byte_idx_r <= byte_idx_nxt;
      tick_r     <= tick_nxt;
      tout_cnt_r <= tout_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_tuser == lsh_pkg::OP_BYTE && byte_idx_r != 2'd3 &&
        (phase_r == lsh_pkg::PH_TX_BODY || phase_r == lsh_pkg::PH_RX_BODY)) begin
      frame_r[byte_idx_r] <= in_tdata;
    end
  end

  assign last_beat = (emit_r.kind == lsh_pkg::FR_NONE) ||
                     (emit_idx_r == lsh_pkg::IDX_W'(lsh_pkg::FRAME_LEN - 1));
  assign emit_done = emit_v_r && out_tready && last_beat;
  assign load      = pend_v_r && (!emit_v_r || emit_done);
  assign in_tready = !pend_v_r || load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
    end else if (in_acc) begin
      pend_v_r <= 1'b1;
    end else if (load) begin
      pend_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      pend_r.kind   <= kind_nxt;
      pend_r.addr   <= frame_r[0];
      pend_r.status <= lsh_pkg::phase_status(phase_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit_v_r   <= 1'b0;
      emit_idx_r <= '0;
    end else if (load) begin
      emit_v_r   <= 1'b1;
      emit_idx_r <= '0;
    end else if (emit_done) begin
      emit_v_r <= 1'b0;
    end else if (emit_v_r && out_tready) begin
      emit_idx_r <= emit_idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      emit_r <= pend_r;
    end
  end

  always_comb begin
    out_byte = 8'h00;
    if (emit_r.kind != lsh_pkg::FR_NONE) begin
      case (emit_idx_r)
        3'd1:    out_byte = (emit_r.kind == lsh_pkg::FR_SET) ? lsh_pkg::ADDR_BYTE : emit_r.addr;
        3'd2:    out_byte = (emit_r.kind == lsh_pkg::FR_SET) ? lsh_pkg::CTRL_SET
                                                              : lsh_pkg::CTRL_UA;
        3'd3:    out_byte = (emit_r.kind == lsh_pkg::FR_SET) ?
                            (lsh_pkg::ADDR_BYTE ^ lsh_pkg::CTRL_SET) :
                            (emit_r.addr ^ lsh_pkg::CTRL_UA);
        default: out_byte = lsh_pkg::FLAG_BYTE;
      endcase
    end
  end

  assign out_tvalid = emit_v_r;
  assign out_tdata  = {6'd0, emit_r.status, out_byte};
  assign out_tuser  = emit_r.kind != lsh_pkg::FR_NONE;
  assign out_tlast  = last_beat;

  a_status_beat_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tlast)
    else $error("status-only beat without last");

  a_frame_opens_with_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser && emit_idx_r == '0 |-> out_tdata[7:0] == lsh_pkg::FLAG_BYTE)
    else $error("frame does not open with a flag");

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    emit_v_r |-> emit_idx_r <= lsh_pkg::IDX_W'(lsh_pkg::FRAME_LEN - 1))
    else $error("serializer index beyond frame");

  a_idle_counters_clear: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == lsh_pkg::PH_IDLE |-> tick_r == 16'd0 && tout_cnt_r == 4'd0)
    else $error("counters running while idle");

  a_no_accept_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && pend_v_r |=> pend_v_r && emit_v_r)
    else $error("holding register lost a descriptor");

endmodule
